>>> hdl/assert_macros.svh
// Assertion macros shared by the ping-pong record buffer RTL.
// They use the clock clk_i and the active-low reset rst_ni of the module
// that includes this header.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// The condition must never be true outside reset.
`define ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition seen");

`endif

>>> hdl/ppr_pkg.sv
// ----------------------------------------------------------------------------
// ppr_pkg
// Types and constants of the ping-pong record buffer.
// ----------------------------------------------------------------------------
package ppr_pkg;

  localparam int unsigned HALF_RECORDS = 32;
  localparam int unsigned RECORD_BITS  = 32;
  localparam int unsigned STORE_DEPTH  = 2 * HALF_RECORDS;
  localparam int unsigned IDX_W        = 5;
  localparam int unsigned ADDR_W       = IDX_W + 1;
  localparam int unsigned LEVEL_W      = 7;
  localparam int unsigned CNT_W        = 32;
  localparam int unsigned FUNC_W       = 3;
  localparam int unsigned STATUS_W     = 2;
  localparam int unsigned REL_W        = 5;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUSH          = 3'd0,
    FUNC_CLAIM_HALF    = 3'd1,
    FUNC_RELEASE_HALF  = 3'd2,
    FUNC_CLAIM_TAIL    = 3'd3,
    FUNC_RELEASE_TAIL  = 3'd4,
    FUNC_CLEAR_DROPPED = 3'd5
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK      = 2'd0,
    STATUS_DROPPED = 2'd1,
    STATUS_EMPTY   = 2'd2
  } status_e;

  typedef enum logic {
    SEQ_IDLE = 1'b0,
    SEQ_RUN  = 1'b1
  } seq_state_e;

  // Status fields reported with every result word.
  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               full_res;
    logic [CNT_W-1:0]   dropped_count;
    logic [CNT_W-1:0]   written_count;
  } rpt_t;

  // Tag that travels alongside a store read.
  typedef struct packed {
    logic             half;
    logic [IDX_W-1:0] idx;
    logic             last;
  } rd_tag_t;

  // Single-word result of a function that is not a claim run.
  typedef struct packed {
    logic    load;
    status_e status;
  } imm_t;

endpackage

>>> hdl/ppr_ram.sv
// ----------------------------------------------------------------------------
// ppr_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ppr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AddrW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/ppr_ctrl.sv
// ----------------------------------------------------------------------------
// ppr_ctrl
// Fill and flush bookkeeping, counters and the claim-run read sequencer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ppr_ctrl (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  input  logic [ppr_pkg::FUNC_W-1:0]           func_i,
  input  logic [ppr_pkg::RECORD_BITS-1:0]      record_in_i,
  input  logic [ppr_pkg::REL_W-1:0]            release_count_i,
  input  logic                                 advance_i,
  output logic                                 in_stall_o,
  output logic                                 ram_we_o,
  output logic [ppr_pkg::ADDR_W-1:0]           ram_waddr_o,
  output logic [ppr_pkg::RECORD_BITS-1:0]      ram_wdata_o,
  output logic                                 ram_re_o,
  output logic [ppr_pkg::ADDR_W-1:0]           ram_raddr_o,
  output logic                                 rd_valid_o,
  output ppr_pkg::rd_tag_t                     rd_tag_o,
  output ppr_pkg::imm_t                        imm_o,
  output ppr_pkg::rpt_t                        rpt_o
);

  import ppr_pkg::*;

  localparam logic [IDX_W-1:0]   LastIdx  = IDX_W'(HALF_RECORDS - 1);
  localparam logic [LEVEL_W-1:0] HalfLvl  = LEVEL_W'(HALF_RECORDS);

  seq_state_e       state_q, state_d;
  logic [IDX_W-1:0] fill_q, fill_d;
  logic             filling_q, filling_d;
  logic [1:0]       flags_q, flags_d;
  logic             flush_q, flush_d;
  logic [CNT_W-1:0] drop_q, drop_d;
  logic [CNT_W-1:0] written_q, written_d;
  logic             run_half_q, run_half_d;
  logic [IDX_W-1:0] run_idx_q, run_idx_d;
  logic [IDX_W-1:0] run_last_q, run_last_d;
  logic             rd_valid_q, rd_valid_d;
  rd_tag_t          rd_tag_q, rd_tag_d;

  logic accept;
  logic start_run;
  logic run_done;

  assign accept   = in_valid_i && !in_stall_o;
  assign run_done = advance_i && (run_idx_q == run_last_q);

  // Architectural state update and run setup.
  always_comb begin
    fill_d     = fill_q;
    filling_d  = filling_q;
    flags_d    = flags_q;
    flush_d    = flush_q;
    drop_d     = drop_q;
    written_d  = written_q;
    run_half_d = run_half_q;
    run_last_d = run_last_q;
    start_run  = 1'b0;
    imm_o      = '{load: 1'b0, status: STATUS_OK};
    ram_we_o   = 1'b0;
    ram_waddr_o = {filling_q, fill_q};
    ram_wdata_o = record_in_i;
    if (accept) begin
      imm_o.load = 1'b1;
      unique case (func_e'(func_i))
        FUNC_PUSH: begin
          if (flags_q[filling_q]) begin
            drop_d       = drop_q + CNT_W'(1);
            imm_o.status = STATUS_DROPPED;
          end else begin
            ram_we_o = 1'b1;
            if (fill_q == LastIdx) begin
              flags_d[filling_q] = 1'b1;
              filling_d          = !filling_q;
              fill_d             = '0;
            end else begin
              fill_d = fill_q + IDX_W'(1);
            end
          end
        end
        FUNC_CLAIM_HALF: begin
          if (!flags_q[flush_q]) begin
            imm_o.status = STATUS_EMPTY;
          end else begin
            imm_o.load = 1'b0;
            start_run  = 1'b1;
            run_half_d = flush_q;
            run_last_d = LastIdx;
          end
        end
        FUNC_RELEASE_HALF: begin
          written_d        = written_q + CNT_W'(HALF_RECORDS);
          flags_d[flush_q] = 1'b0;
          flush_d          = !flush_q;
        end
        FUNC_CLAIM_TAIL: begin
          if (fill_q == '0) begin
            imm_o.status = STATUS_EMPTY;
          end else begin
            imm_o.load = 1'b0;
            start_run  = 1'b1;
            run_half_d = filling_q;
            run_last_d = fill_q - IDX_W'(1);
          end
        end
        FUNC_RELEASE_TAIL: begin
          written_d = written_q + CNT_W'(release_count_i);
          fill_d    = '0;
        end
        FUNC_CLEAR_DROPPED: begin
          drop_d = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SEQ_IDLE: if (start_run) state_d = SEQ_RUN;
      SEQ_RUN:  if (run_done) state_d = SEQ_IDLE;
      default:  state_d = SEQ_IDLE;
    endcase
  end

  // Sequencer outputs. A read is issued only when the stage after the RAM
  // register can move, so the RAM register doubles as a pipeline stage.
  always_comb begin
    in_stall_o = 1'b1;
    ram_re_o   = 1'b0;
    run_idx_d  = run_idx_q;
    unique case (state_q)
      SEQ_IDLE: begin
        in_stall_o = rd_valid_q || !advance_i;
        if (start_run) run_idx_d = '0;
      end
      SEQ_RUN: begin
        ram_re_o = advance_i;
        if (advance_i) run_idx_d = run_idx_q + IDX_W'(1);
      end
      default: begin
      end
    endcase
  end

  assign ram_raddr_o = {run_half_q, run_idx_q};

  always_comb begin
    rd_valid_d = rd_valid_q;
    rd_tag_d   = rd_tag_q;
    if (advance_i) begin
      rd_valid_d = ram_re_o;
      rd_tag_d   = '{half: run_half_q, idx: run_idx_q, last: run_idx_q == run_last_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= SEQ_IDLE;
      fill_q     <= '0;
      filling_q  <= 1'b0;
      flags_q    <= '0;
      flush_q    <= 1'b0;
      drop_q     <= '0;
      written_q  <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      fill_q     <= fill_d;
      filling_q  <= filling_d;
      flags_q    <= flags_d;
      flush_q    <= flush_d;
      drop_q     <= drop_d;
      written_q  <= written_d;
      rd_valid_q <= rd_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    run_half_q <= run_half_d;
    run_idx_q  <= run_idx_d;
    run_last_q <= run_last_d;
    rd_tag_q   <= rd_tag_d;
  end

  // The report reflects the state after the current word is applied; during
  // a run nothing changes, so the same logic serves run results.
  always_comb begin
    rpt_o.level = LEVEL_W'(fill_d);
    if (flags_d[0]) rpt_o.level = rpt_o.level + HalfLvl;
    if (flags_d[1]) rpt_o.level = rpt_o.level + HalfLvl;
    rpt_o.full_res      = flags_d[filling_d];
    rpt_o.dropped_count = drop_d;
    rpt_o.written_count = written_d;
  end

  assign rd_valid_o = rd_valid_q;
  assign rd_tag_o   = rd_tag_q;

  // No push may land in the store while a claim run still reads it.
  `ASSERT_NEVER(a_no_write_during_run, ram_we_o && (state_q == SEQ_RUN || rd_valid_q))
  `ASSERT_CLK(a_run_idx_bound, (state_q == SEQ_RUN) |-> (run_idx_q <= run_last_q))
  `ASSERT_CLK(a_read_held_on_stall, (rd_valid_q && !advance_i) |=> (rd_valid_q && $stable(rd_tag_q)))

endmodule

>>> hdl/ping_pong_record_buffer.sv
// ----------------------------------------------------------------------------
// ping_pong_record_buffer
// Two-half ping-pong record buffer with claim runs and drop/written counters.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake                 Payload
//   in       to block   in_valid_i / in_stall_o   func_i, record_in_i, release_count_i
//   out      from block out_valid_o / out_stall_i status_o ... written_count_o
//
// The result word of a push, release or clear is registered.
// A claim run delivers one record per cycle while the output does not stall,
// set by the single read port of the record store; the next word is taken
// once the last record has left the store read register.
// Reset clears the sequencer state, fill and flush state, counters and valid flags; the record store is not cleared.
// A stall on the output holds the store read and the output register in place.
`include "assert_macros.svh"

module ping_pong_record_buffer (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [ppr_pkg::FUNC_W-1:0]           func_i,
  input  logic [ppr_pkg::RECORD_BITS-1:0]      record_in_i,
  input  logic [ppr_pkg::REL_W-1:0]            release_count_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [ppr_pkg::STATUS_W-1:0]         status_o,
  output logic [ppr_pkg::RECORD_BITS-1:0]      record_out_o,
  output logic                                 half_sel_o,
  output logic [ppr_pkg::IDX_W-1:0]            record_index_o,
  output logic                                 last_o,
  output logic [ppr_pkg::LEVEL_W-1:0]          level_o,
  output logic                                 full_res_o,
  output logic [ppr_pkg::CNT_W-1:0]            dropped_count_o,
  output logic [ppr_pkg::CNT_W-1:0]            written_count_o
);

  import ppr_pkg::*;

  logic                   advance;
  logic                   ram_we;
  logic [ADDR_W-1:0]      ram_waddr;
  logic [RECORD_BITS-1:0] ram_wdata;
  logic                   ram_re;
  logic [ADDR_W-1:0]      ram_raddr;
  logic [RECORD_BITS-1:0] ram_rdata;
  logic                   rd_valid;
  rd_tag_t                rd_tag;
  imm_t                   imm;
  rpt_t                   rpt;

  logic                   out_valid_q, out_valid_d;
  status_e                status_q, status_d;
  logic [RECORD_BITS-1:0] record_q, record_d;
  rd_tag_t                tag_q, tag_d;
  rpt_t                   rpt_q, rpt_d;

  assign advance = !out_valid_q || !out_stall_i;

  ppr_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .func_i          (func_i),
    .record_in_i     (record_in_i),
    .release_count_i (release_count_i),
    .advance_i       (advance),
    .in_stall_o      (in_stall_o),
    .ram_we_o        (ram_we),
    .ram_waddr_o     (ram_waddr),
    .ram_wdata_o     (ram_wdata),
    .ram_re_o        (ram_re),
    .ram_raddr_o     (ram_raddr),
    .rd_valid_o      (rd_valid),
    .rd_tag_o        (rd_tag),
    .imm_o           (imm),
    .rpt_o           (rpt)
  );

  ppr_ram #(
    .WIDTH (RECORD_BITS),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Output register: a store record of a run or a single result word.
  always_comb begin
    out_valid_d = out_valid_q;
    status_d    = status_q;
    record_d    = record_q;
    tag_d       = tag_q;
    rpt_d       = rpt_q;
    if (advance) begin
      out_valid_d = rd_valid || imm.load;
      rpt_d       = rpt;
      if (rd_valid) begin
        status_d = STATUS_OK;
        record_d = ram_rdata;
        tag_d    = rd_tag;
      end else begin
        status_d = imm.status;
        record_d = '0;
        tag_d    = '{half: 1'b0, idx: '0, last: 1'b1};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    record_q <= record_d;
    tag_q    <= tag_d;
    rpt_q    <= rpt_d;
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign record_out_o    = record_q;
  assign half_sel_o      = tag_q.half;
  assign record_index_o  = tag_q.idx;
  assign last_o          = tag_q.last;
  assign level_o         = rpt_q.level;
  assign full_res_o      = rpt_q.full_res;
  assign dropped_count_o = rpt_q.dropped_count;
  assign written_count_o = rpt_q.written_count;

  // A store record and a single result word never compete for the register.
  `ASSERT_NEVER(a_one_source, rd_valid && imm.load)
  `ASSERT_CLK(a_no_accept_while_reading, rd_valid |-> in_stall_o)

endmodule
